// File: hw/rtl/ddmr_pkg.sv
// ddmr_pkg: shared codes, widths, constants and helper functions for the
// differential-drive move regulator and its port checker.
// No dependencies.
package ddmr_pkg;

  // item kinds on the input stream
  typedef enum logic [1:0] {
    FUNC_POLL   = 2'd0,
    FUNC_SET    = 2'd1,
    FUNC_STOP   = 2'd2,
    FUNC_RESUME = 2'd3
  } func_t;

  // halt cause carried with each result beat
  typedef enum logic [1:0] {
    CAUSE_RUN    = 2'd0,
    CAUSE_TARGET = 2'd1,
    CAUSE_STUCK  = 2'd2,
    CAUSE_STOP   = 2'd3
  } cause_t;

  // motion state, one-hot
  typedef enum logic [2:0] {
    MODE_IDLE = 3'b001,
    MODE_FWD  = 3'b010,
    MODE_TURN = 3'b100
  } mode_t;

  // register map indexes
  localparam logic [1:0] REG_GAIN   = 2'd0;
  localparam logic [1:0] REG_CRUISE = 2'd1;
  localparam logic [1:0] REG_MIN    = 2'd2;
  localparam logic [1:0] REG_STUCK  = 2'd3;

  // field widths
  localparam int GAIN_W   = 10;
  localparam int SPEED_W  = 7;
  localparam int STUCK_W  = 16;
  localparam int AMT_W    = 18;
  localparam int ENC_W    = 32;
  localparam int CORR_W   = 32;
  localparam int NEAR_W   = 8;
  localparam int OUT_W    = 8;
  localparam int FRAC_W   = 10;
  localparam int PROD_W   = 16;

  // register reset values
  localparam logic [GAIN_W-1:0]  GAIN_RST   = 10'd300;
  localparam logic [SPEED_W-1:0] CRUISE_RST = 7'd30;
  localparam logic [SPEED_W-1:0] MIN_RST    = 7'd2;
  localparam logic [STUCK_W-1:0] STUCK_RST  = 16'd500;

  // ramp length in ticks at each end of a move
  localparam int RAMP_TICKS = 200;

  // profile divide by the ramp length: reciprocal multiply
  localparam int PROF_SHIFT = 24;
  localparam longint unsigned PROF_MULT_L =
    ((64'd1 << PROF_SHIFT) + 64'(RAMP_TICKS) - 64'd1) / 64'(RAMP_TICKS);
  localparam logic [31:0] PROF_MULT = 32'(PROF_MULT_L);

  // distance and angle to ticks
  localparam int FWD_UM_PER_TICK   = 628319 / 360;
  localparam int ROT_MDEG_PER_TICK = 57296 * FWD_UM_PER_TICK / 294800;
  localparam int FWD_NUM           = 4 * 1000;
  localparam int ROT_NUM           = 2 * 1000;
  localparam int TGT_SHIFT         = 28;
  localparam int TGT_PROD_W        = AMT_W + 32;
  localparam int TGT_Q_W           = 21;
  localparam longint unsigned FWD_MULT_L =
    ((64'(FWD_NUM) << TGT_SHIFT) + 64'(FWD_UM_PER_TICK) - 64'd1) / 64'(FWD_UM_PER_TICK);
  localparam longint unsigned ROT_MULT_L =
    ((64'(ROT_NUM) << TGT_SHIFT) + 64'(ROT_MDEG_PER_TICK) - 64'd1) / 64'(ROT_MDEG_PER_TICK);
  localparam logic [31:0] FWD_MULT = 32'(FWD_MULT_L);
  localparam logic [31:0] ROT_MULT = 32'(ROT_MULT_L);

  // decision stage to product stage
  typedef struct packed {
    logic               fixed;
    cause_t             cause;
    logic               turn;
    logic               dist_pos;
    logic [NEAR_W-1:0]  near;
    logic               err_neg;
    logic [CORR_W-1:0]  err_q;
    logic [FRAC_W-1:0]  err_r;
  } st2_t;

  // product stage to speed stage
  typedef struct packed {
    logic               fixed;
    cause_t             cause;
    logic               turn;
    logic               dist_pos;
    logic [PROD_W-1:0]  prod;
    logic [CORR_W-1:0]  corr;
  } st3_t;

  // unsigned skew correction, wrapped to 32 bits
  function automatic logic [CORR_W-1:0] corr_mag(input logic [CORR_W-1:0] q,
                                                 input logic [FRAC_W-1:0] r,
                                                 input logic [GAIN_W-1:0] gain);
    logic [CORR_W-1:0]        qg;
    logic [FRAC_W+GAIN_W-1:0] rg;
    qg = CORR_W'(q * CORR_W'(gain));
    rg = (FRAC_W+GAIN_W)'(r) * (FRAC_W+GAIN_W)'(gain);
    return qg + CORR_W'(rg[FRAC_W+GAIN_W-1:FRAC_W]);
  endfunction

  // magnitude of a 32-bit two's complement word
  function automatic logic [CORR_W-1:0] mag32(input logic [CORR_W-1:0] v);
    return v[CORR_W-1] ? (~v + 1'b1) : v;
  endfunction

endpackage

// File: hw/rtl/diff_drive_motion_regulator.sv
// diff_drive_motion_regulator: top level of the move regulator, a four-register
// pipeline with an APB register block.
// Depends on ddmr_pkg.
//
// Usage
//   s_* stream: one beat per command (poll encoders, set target, stop, resume).
//   m_* stream: speed beats for both motors with a halt cause. Polls while
//   moving and stop commands give one beat; set target, resume and polls
//   while idle give none.
//   APB port: feedback_gain, cruise_speed, min_speed, stuck_limit at 0x0,
//   0x4, 0x8, 0xC; write only while no command is in flight.
// Timing
//   one beat accepted per cycle while s_tready is high. The stages, in
//   order from command beat to m_tvalid, are: input register, decision stage
//   (motion, skew, ramp distance, stop checks, state update), product stage
//   (ramp product, skew correction multiply), speed stage (ramp divide by
//   reciprocal multiply, speed mix) into the output register.
// Reset
//   synchronous; registers go to their defaults, motion goes idle and the
//   pipeline empties.
// Stall
//   a held m_tready freezes the output beat; the stages behind it keep
//   filling bubbles and s_tready falls only when every stage holds a beat.
module diff_drive_motion_regulator #(
  parameter int POSITION_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  // command stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [87:0] s_tdata,   // target_amount[17:0], encoder_left[49:18],
                                 // encoder_right[81:50], zero pad[87:82]
  input  logic [2:0]  s_tuser,   // func[1:0], move_mode[2]
  // speed stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // left_speed[7:0], right_speed[15:8]
  output logic [1:0]  m_tuser,   // halt_cause[1:0]
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import ddmr_pkg::*;

  localparam int PW = POSITION_WIDTH;

  // configuration registers
  logic [GAIN_W-1:0]  feedback_gain;
  logic [SPEED_W-1:0] cruise_speed;
  logic [SPEED_W-1:0] min_speed;
  logic [STUCK_W-1:0] stuck_limit;
  logic               cfg_wr;
  logic               cfg_touched;

  // move state
  mode_t                motion_mode, mode_next;
  mode_t                saved_mode, saved_next;
  logic signed [PW-1:0] target_ticks, target_next;
  logic signed [PW-1:0] origin_left, origin_left_next;
  logic signed [PW-1:0] origin_right, origin_right_next;
  logic signed [PW-1:0] last_motion, last_motion_next;
  logic [STUCK_W-1:0]   stuck_count, stuck_next;
  logic [NEAR_W-1:0]    last_near;
  logic [CORR_W-1:0]    last_q;
  logic [FRAC_W-1:0]    last_r;
  logic [OUT_W-1:0]     last_profile_speed;
  logic [CORR_W-1:0]    last_correction;

  // pipeline registers
  logic                    v1, v2, v3;
  logic                    rdy1, rdy2, rdy3, adv4, fire1;
  func_t                   r1_func;
  logic                    r1_move_mode;
  logic signed [AMT_W-1:0] r1_amount;
  logic signed [ENC_W-1:0] r1_enc_left, r1_enc_right;
  st2_t                    st2, st2_next;
  st3_t                    st3, st3_next;
  logic                    emit, run_poll;

  // apb register block
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      feedback_gain <= GAIN_RST;
      cruise_speed  <= CRUISE_RST;
      min_speed     <= MIN_RST;
      stuck_limit   <= STUCK_RST;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_GAIN:   feedback_gain <= pwdata[GAIN_W-1:0];
        REG_CRUISE: cruise_speed  <= pwdata[SPEED_W-1:0];
        REG_MIN:    min_speed     <= pwdata[SPEED_W-1:0];
        REG_STUCK:  stuck_limit   <= pwdata[STUCK_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_GAIN:   prdata = 32'(feedback_gain);
      REG_CRUISE: prdata = 32'(cruise_speed);
      REG_MIN:    prdata = 32'(min_speed);
      REG_STUCK:  prdata = 32'(stuck_limit);
      default:    prdata = '0;
    endcase
  end

  // ready chain, one bubble-collapsing slot per stage
  assign adv4     = !m_tvalid || m_tready;
  assign rdy3     = !v3 || adv4;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign s_tready = rdy1;
  assign fire1    = v1 && rdy2;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (rdy1) begin
      v1 <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && rdy1) begin
      r1_func      <= func_t'(s_tuser[1:0]);
      r1_move_mode <= s_tuser[2];
      r1_amount    <= s_tdata[17:0];
      r1_enc_left  <= s_tdata[49:18];
      r1_enc_right <= s_tdata[81:50];
    end
  end

  // target in ticks: sign * floor(|amount| * num / den) via reciprocal
  logic                  amt_neg;
  logic [AMT_W-1:0]      amt_mag;
  logic [31:0]           tgt_mult;
  logic [TGT_PROD_W-1:0] tgt_prod;
  logic [TGT_Q_W-1:0]    tgt_q;
  logic signed [TGT_Q_W:0] tgt_s;
  logic signed [PW-1:0]  tgt_ticks;

  always_comb begin
    amt_neg   = r1_amount[AMT_W-1];
    amt_mag   = amt_neg ? AMT_W'(-r1_amount) : AMT_W'(r1_amount);
    tgt_mult  = r1_move_mode ? ROT_MULT : FWD_MULT;
    tgt_prod  = TGT_PROD_W'(amt_mag) * TGT_PROD_W'(tgt_mult);
    tgt_q     = tgt_prod[TGT_SHIFT +: TGT_Q_W];
    tgt_s     = amt_neg ? -$signed({1'b0, tgt_q}) : $signed({1'b0, tgt_q});
    tgt_ticks = PW'(tgt_s);
  end

  // motion, skew and ramp distance
  logic signed [PW-1:0] enc_l, enc_r, dl, dr, motion, err, remain;
  logic [PW-1:0]        dmag, mmag, emag, near_mag;
  logic [NEAR_W-1:0]    near;
  logic                 is_turn, dist_pos;

  always_comb begin
    is_turn  = (motion_mode == MODE_TURN);
    enc_l    = PW'(r1_enc_left);
    enc_r    = PW'(r1_enc_right);
    dl       = enc_l - origin_left;
    dr       = enc_r - origin_right;
    motion   = is_turn ? (dl - dr) : (dl + dr);
    err      = is_turn ? (dl + dr) : (dl - dr);
    remain   = target_ticks - motion;
    dmag     = remain[PW-1] ? $unsigned(-remain) : $unsigned(remain);
    mmag     = motion[PW-1] ? $unsigned(-motion) : $unsigned(motion);
    emag     = err[PW-1]    ? $unsigned(-err)    : $unsigned(err);
    near_mag = (dmag < mmag) ? dmag : mmag;
    near     = (near_mag > PW'(RAMP_TICKS)) ? NEAR_W'(RAMP_TICKS) : near_mag[NEAR_W-1:0];
    dist_pos = (remain != '0) && !remain[PW-1];
  end

  // slow-last-speed check: rebuilt from the last poll's inputs while the
  // registers are unchanged, else read from the stored speeds
  logic [PROD_W-1:0] last_prod, prof_lim;
  logic [OUT_W-1:0]  lps_mag;
  logic [CORR_W-1:0] cmag_live, cmag_kept;
  logic              prof_slow, corr_slow, reach;
  logic [STUCK_W-1:0] stuck_inc;

  always_comb begin
    last_prod = PROD_W'(last_near) * PROD_W'(cruise_speed);
    prof_lim  = PROD_W'((PROD_W'(min_speed) + 1'b1) * PROD_W'(RAMP_TICKS));
    lps_mag   = last_profile_speed[OUT_W-1] ? (~last_profile_speed + 1'b1)
                                            : last_profile_speed;
    cmag_live = mag32(corr_mag(last_q, last_r, feedback_gain));
    cmag_kept = mag32(last_correction);
    if (cfg_touched) begin
      prof_slow = (lps_mag <= OUT_W'(min_speed));
      corr_slow = (cmag_kept <= CORR_W'(min_speed));
    end else begin
      prof_slow = (last_prod < prof_lim);
      corr_slow = (cmag_live <= CORR_W'(min_speed));
    end
    reach = (remain == '0) && prof_slow && corr_slow;
    if (motion == last_motion) begin
      stuck_inc = (stuck_count == '1) ? stuck_count : stuck_count + 1'b1;
    end else begin
      stuck_inc = '0;
    end
  end

  // command decode and state update
  always_comb begin
    mode_next         = motion_mode;
    saved_next        = saved_mode;
    target_next       = target_ticks;
    origin_left_next  = origin_left;
    origin_right_next = origin_right;
    last_motion_next  = last_motion;
    stuck_next        = stuck_count;
    emit              = 1'b0;
    run_poll          = 1'b0;
    st2_next          = '0;
    st2_next.cause    = CAUSE_RUN;
    st2_next.turn     = is_turn;
    st2_next.dist_pos = dist_pos;
    st2_next.near     = near;
    st2_next.err_neg  = err[PW-1];
    st2_next.err_q    = CORR_W'(emag >> FRAC_W);
    st2_next.err_r    = emag[FRAC_W-1:0];
    case (r1_func)
      FUNC_SET: begin
        mode_next         = r1_move_mode ? MODE_TURN : MODE_FWD;
        target_next       = tgt_ticks;
        origin_left_next  = enc_l;
        origin_right_next = enc_r;
        last_motion_next  = '0;
        stuck_next        = '0;
      end
      FUNC_STOP: begin
        saved_next     = motion_mode;
        mode_next      = MODE_IDLE;
        emit           = 1'b1;
        st2_next.fixed = 1'b1;
        st2_next.cause = CAUSE_STOP;
      end
      FUNC_RESUME: begin
        mode_next = saved_mode;
      end
      FUNC_POLL: begin
        if (motion_mode != MODE_IDLE) begin
          emit = 1'b1;
          if (reach) begin
            saved_next     = motion_mode;
            mode_next      = MODE_IDLE;
            st2_next.fixed = 1'b1;
            st2_next.cause = CAUSE_TARGET;
          end else begin
            stuck_next = stuck_inc;
            if (stuck_inc >= stuck_limit) begin
              saved_next     = motion_mode;
              mode_next      = MODE_IDLE;
              st2_next.fixed = 1'b1;
              st2_next.cause = CAUSE_STUCK;
            end else begin
              run_poll         = 1'b1;
              last_motion_next = motion;
            end
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      motion_mode  <= MODE_IDLE;
      saved_mode   <= MODE_IDLE;
      target_ticks <= '0;
      origin_left  <= '0;
      origin_right <= '0;
      last_motion  <= '0;
      stuck_count  <= '0;
      last_near    <= '0;
      last_q       <= '0;
      last_r       <= '0;
    end else if (fire1) begin
      motion_mode  <= mode_next;
      saved_mode   <= saved_next;
      target_ticks <= target_next;
      origin_left  <= origin_left_next;
      origin_right <= origin_right_next;
      last_motion  <= last_motion_next;
      stuck_count  <= stuck_next;
      if (run_poll) begin
        last_near <= near;
        last_q    <= st2_next.err_q;
        last_r    <= st2_next.err_r;
      end
    end
  end

  // track register writes since the last running poll
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_touched <= 1'b1;
    end else if (cfg_wr) begin
      cfg_touched <= 1'b1;
    end else if (fire1 && run_poll) begin
      cfg_touched <= 1'b0;
    end
  end

  // decision stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (rdy2) begin
      v2 <= v1 && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (fire1 && emit) begin
      st2 <= st2_next;
    end
  end

  // product stage: ramp product and signed skew correction
  logic [CORR_W-1:0] corr_abs;

  always_comb begin
    corr_abs          = corr_mag(st2.err_q, st2.err_r, feedback_gain);
    st3_next.fixed    = st2.fixed;
    st3_next.cause    = st2.cause;
    st3_next.turn     = st2.turn;
    st3_next.dist_pos = st2.dist_pos;
    st3_next.prod     = PROD_W'(st2.near) * PROD_W'(cruise_speed);
    st3_next.corr     = st2.err_neg ? (~corr_abs + 1'b1) : corr_abs;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (rdy3) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (v2 && rdy3) begin
      st3 <= st3_next;
    end
  end

  // speed stage: divide by ramp length, clamp to min speed, mix skew
  logic [31:0]        prof_full;
  logic [SPEED_W-1:0] prof, smag;
  logic [OUT_W-1:0]   ts, c8, left_spd, right_spd;

  always_comb begin
    prof_full = 32'(st3.prod) * PROF_MULT;
    prof      = prof_full[PROF_SHIFT +: SPEED_W];
    smag      = (prof > min_speed) ? prof : min_speed;
    ts        = st3.dist_pos ? {1'b0, smag} : (~{1'b0, smag} + 1'b1);
    c8        = st3.corr[OUT_W-1:0];
    left_spd  = ts - c8;
    right_spd = st3.turn ? ((~ts + 1'b1) - c8) : (ts + c8);
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv4) begin
      m_tvalid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (v3 && adv4) begin
      if (st3.fixed) begin
        m_tdata <= '0;
      end else begin
        m_tdata <= {right_spd, left_spd};
      end
      m_tuser <= st3.cause;
    end
  end

  // speeds of the last running poll
  always_ff @(posedge clk) begin
    if (rst) begin
      last_profile_speed <= '0;
      last_correction    <= '0;
    end else if (v3 && adv4 && !st3.fixed) begin
      last_profile_speed <= ts;
      last_correction    <= st3.corr;
    end
  end

endmodule

// File: hw/rtl/ddmr_checker.sv
// ddmr_checker: port-level checks on the move regulator, bound to the top.
// Depends on ddmr_pkg and diff_drive_motion_regulator.
module ddmr_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata,
  input logic [1:0]  m_tuser
);
  import ddmr_pkg::*;

  // a stalled result beat holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result beat changed while stalled");

  // halted beats carry zero speeds
  a_halt_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser != CAUSE_RUN) |-> (m_tdata == 16'd0))
    else $error("halt beat with nonzero speed");

  // input side is open whenever the output register can move
  a_no_bubble_stall: assert property (@(posedge clk) disable iff (rst)
    (m_tready || !m_tvalid) |-> s_tready)
    else $error("input stalled with a free output register");

  // reset empties the output
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result beat right after reset");

endmodule

bind diff_drive_motion_regulator ddmr_checker u_ddmr_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
